// ----- sv/rhsv_pkg.sv -----
// Shared widths, constants and pipeline lane types for the RGB to HSV converter.
package rhsv_pkg;

	localparam int CH_W   = 8;
	localparam int HUE_W  = 15;
	localparam int HQ_W   = 12;
	localparam int SQ_W   = 8;
	localparam int HREM_W = 20;
	localparam int SREM_W = 16;

	// One quotient bit of the hue divide per stage; saturation bits ride in the last stages.
	localparam int DIV_STAGES = HQ_W;

	localparam int HUE_PER_DEG = 64;

	localparam logic [HUE_W-1:0] HUE_TURN  = HUE_W'(360 * HUE_PER_DEG);
	localparam logic [HUE_W-1:0] HUE_GREEN = HUE_W'(120 * HUE_PER_DEG);
	localparam logic [HUE_W-1:0] HUE_BLUE  = HUE_W'(240 * HUE_PER_DEG);

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	typedef struct packed {
		logic [HREM_W-1:0] hrem;
		logic [HQ_W-1:0]   hq;
		logic [SREM_W-1:0] srem;
		logic [SQ_W-1:0]   sq;
		logic [CH_W-1:0]   hdiv;
		logic [CH_W-1:0]   sdiv;
		logic              neg;
		sector_t           sector;
	} div_lane_t;

endpackage

// ----- sv/rhsv_front.sv -----
// Front end: channel max/min, sector pick, signed hue numerator and divider operands.
module rhsv_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [7:0]              red,
	input  logic [7:0]              green,
	input  logic [7:0]              blue,
	output logic                    out_valid,
	output rhsv_pkg::div_lane_t     out_lane
);
	import rhsv_pkg::*;

	logic [CH_W-1:0] top;
	logic [CH_W-1:0] bottom;
	sector_t         sector;

	logic            vld_s1;
	logic [CH_W-1:0] red_s1;
	logic [CH_W-1:0] green_s1;
	logic [CH_W-1:0] blue_s1;
	logic [CH_W-1:0] top_s1;
	logic [CH_W-1:0] bottom_s1;
	sector_t         sector_s1;

	logic [CH_W-1:0] delta;
	logic [CH_W:0]   num;
	logic [CH_W:0]   mag;
	logic [CH_W-1:0] mag8;
	div_lane_t       lane;

	logic            vld_s2;
	div_lane_t       lane_s2;

	always_comb begin
		top    = red;
		bottom = red;
		if (green > top)
			top = green;
		if (blue > top)
			top = blue;
		if (green < bottom)
			bottom = green;
		if (blue < bottom)
			bottom = blue;
		// ties: red wins over green, green over blue
		if (top == red)
			sector = SECT_RED;
		else if (top == green)
			sector = SECT_GREEN;
		else
			sector = SECT_BLUE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1    <= red;
			green_s1  <= green;
			blue_s1   <= blue;
			top_s1    <= top;
			bottom_s1 <= bottom;
			sector_s1 <= sector;
		end
	end

	always_comb begin
		delta = top_s1 - bottom_s1;
		case (sector_s1)
			SECT_RED:   num = {1'b0, green_s1} - {1'b0, blue_s1};
			SECT_GREEN: num = {1'b0, blue_s1} - {1'b0, red_s1};
			SECT_BLUE:  num = {1'b0, red_s1} - {1'b0, green_s1};
			default:    num = '0;
		endcase
		mag  = num[CH_W] ? (~num + 1'b1) : num;
		mag8 = mag[CH_W-1:0];

		lane        = '0;
		// 3840 * |num| and 255 * delta as shift-and-subtract
		lane.hrem   = {mag8, 12'd0} - {4'd0, mag8, 8'd0};
		lane.srem   = {delta, 8'd0} - {8'd0, delta};
		lane.hdiv   = delta;
		lane.sdiv   = top_s1;
		lane.neg    = num[CH_W];
		lane.sector = sector_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en)
			lane_s2 <= lane;
	end

	assign out_valid = vld_s2;
	assign out_lane  = lane_s2;

endmodule

// ----- sv/rhsv_divider.sv -----
// Pipelined restoring dividers: a hue quotient bit per stage, plus a saturation bit in the last eight.
module rhsv_divider (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  rhsv_pkg::div_lane_t     in_lane,
	output logic                    out_valid,
	output rhsv_pkg::div_lane_t     out_lane
);
	import rhsv_pkg::*;

	logic [DIV_STAGES-1:0] vld_s;
	logic [DIV_STAGES-1:0] vld_in;
	div_lane_t             pipe_s [DIV_STAGES];
	div_lane_t             lane_in [DIV_STAGES];
	div_lane_t             lane_nxt [DIV_STAGES];

	genvar k;
	generate
		for (k = 0; k < DIV_STAGES; k++) begin : g_stage
			localparam int QB = DIV_STAGES - 1 - k;

			logic [HREM_W-1:0] hshift;

			if (k == 0) begin : g_first
				assign lane_in[k] = in_lane;
				assign vld_in[k]  = in_valid;
			end else begin : g_next
				assign lane_in[k] = pipe_s[k-1];
				assign vld_in[k]  = vld_s[k-1];
			end

			assign hshift = HREM_W'(lane_in[k].hdiv) << QB;

			if (QB < SQ_W) begin : g_sat
				logic [SREM_W-1:0] sshift;

				assign sshift = SREM_W'(lane_in[k].sdiv) << QB;

				always_comb begin
					lane_nxt[k] = lane_in[k];
					if (lane_in[k].hrem >= hshift) begin
						lane_nxt[k].hrem   = lane_in[k].hrem - hshift;
						lane_nxt[k].hq[QB] = 1'b1;
					end
					if (lane_in[k].srem >= sshift) begin
						lane_nxt[k].srem   = lane_in[k].srem - sshift;
						lane_nxt[k].sq[QB] = 1'b1;
					end
				end
			end else begin : g_hue_only
				always_comb begin
					lane_nxt[k] = lane_in[k];
					if (lane_in[k].hrem >= hshift) begin
						lane_nxt[k].hrem   = lane_in[k].hrem - hshift;
						lane_nxt[k].hq[QB] = 1'b1;
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[k] <= 1'b0;
				else if (en)
					vld_s[k] <= vld_in[k];
			end

			always_ff @(posedge clk) begin
				if (en)
					pipe_s[k] <= lane_nxt[k];
			end
		end
	endgenerate

	assign out_valid = vld_s[DIV_STAGES-1];
	assign out_lane  = pipe_s[DIV_STAGES-1];

endmodule

// ----- sv/rhsv_back.sv -----
// Back end: sign and sector offset on the hue quotient, grey and black cases, output register.
module rhsv_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  rhsv_pkg::div_lane_t     in_lane,
	output logic                    out_valid,
	output logic [14:0]             hue,
	output logic [7:0]              saturation,
	output logic [7:0]              brightness
);
	import rhsv_pkg::*;

	logic [HUE_W-1:0] base;
	logic [HUE_W-1:0] frac;
	logic [HUE_W-1:0] hue_d;
	logic [SQ_W-1:0]  sat_d;

	logic             vld_s15;
	logic [HUE_W-1:0] hue_s15;
	logic [SQ_W-1:0]  sat_s15;
	logic [CH_W-1:0]  bright_s15;

	always_comb begin
		case (in_lane.sector)
			// negative red-sector hue wraps up below a full turn
			SECT_RED:   base = in_lane.neg ? HUE_TURN : '0;
			SECT_GREEN: base = HUE_GREEN;
			SECT_BLUE:  base = HUE_BLUE;
			default:    base = '0;
		endcase
		frac  = HUE_W'(in_lane.hq);
		hue_d = in_lane.neg ? (base - frac) : (base + frac);
		if (in_lane.hdiv == '0)
			hue_d = '0;
		sat_d = (in_lane.sdiv == '0) ? '0 : in_lane.sq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s15 <= 1'b0;
		else if (en)
			vld_s15 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s15    <= hue_d;
			sat_s15    <= sat_d;
			bright_s15 <= in_lane.sdiv;
		end
	end

	assign out_valid  = vld_s15;
	assign hue        = hue_s15;
	assign saturation = sat_s15;
	assign brightness = bright_s15;

endmodule

// ----- sv/rgb_to_hsv_converter.sv -----
// RGB to HSV converter top level: front end, divider pipeline and output stage.
//
// Input channel: pixel_valid / pixel_stall with red, green, blue (8 bits each).
// Output channel: hsv_valid / hsv_stall with hue (degrees * 64, 0..23039),
// saturation (0..255) and brightness (the largest channel).
// A transaction moves when valid is high and stall is low at a rising clk edge.
//
// The pipeline has two front stages (max/min, then numerator and divider
// operands), twelve restoring-divide stages that each settle one hue quotient
// bit (the last eight also settle one saturation bit), and the output register.
// Throughput is one pixel per cycle unless stalled; the divide sets the depth.
//
// The whole pipeline advances on one enable. While hsv_valid is high and
// hsv_stall is high, every stage holds and pixel_stall is raised; empty slots
// never block, so pixel_stall is low whenever the output register is empty.
// Reset (arst_n low) clears all stage valid bits; no results are pending after.
module rgb_to_hsv_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        hsv_valid,
	input  logic        hsv_stall,
	output logic [14:0] hue,
	output logic [7:0]  saturation,
	output logic [7:0]  brightness
);
	import rhsv_pkg::*;

	logic      en;
	logic      front_valid;
	div_lane_t front_lane;
	logic      div_valid;
	div_lane_t div_lane;

	// hold every stage while the finished result waits
	assign en          = !(hsv_valid && hsv_stall);
	assign pixel_stall = !en;

	rhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pixel_valid),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (front_valid),
		.out_lane  (front_lane)
	);

	rhsv_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.in_lane   (front_lane),
		.out_valid (div_valid),
		.out_lane  (div_lane)
	);

	rhsv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (div_valid),
		.in_lane    (div_lane),
		.out_valid  (hsv_valid),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hue < HUE_TURN)
		else $error("hue out of range");

	a_black_unsaturated: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && brightness == '0 |-> saturation == '0 && hue == '0)
		else $error("black pixel with nonzero saturation or hue");

	a_grey_no_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && saturation == '0 |-> hue == '0)
		else $error("grey pixel with nonzero hue");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv_stall |=> hsv_valid && $stable(hue) && $stable(saturation)
			&& $stable(brightness))
		else $error("stalled transaction changed");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the RGB to HSV converter: directed table, then random pixels.
`timescale 1ns / 100ps

module testbench;
	import rhsv_pkg::*;

	localparam int NUM_DIRECTED   = 22;
	localparam int NUM_RANDOM     = 2000;
	localparam int QUIET_TAIL     = 300;
	localparam int HOLD_AT_ITEM   = 600;
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_CYCLES   = 40;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int HUE_PER_SIXTY  = 60 * HUE_PER_DEG;
	localparam int CH_MAX         = (1 << CH_W) - 1;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  sat;
		logic [CH_W-1:0]  val;
	} hsv_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic            typed;
		hsv_t            want;
	} pixel_case_t;

	logic             clk;
	logic             arst_n;
	logic             pixel_valid;
	logic             pixel_stall;
	logic [CH_W-1:0]  red;
	logic [CH_W-1:0]  green;
	logic [CH_W-1:0]  blue;
	logic             hsv_valid;
	logic             hsv_stall;
	logic [HUE_W-1:0] hue;
	logic [CH_W-1:0]  saturation;
	logic [CH_W-1:0]  brightness;

	hsv_t hsv_expected_q[$];
	hsv_t oldest_hsv;
	int   fail_count;
	int   pixels_sent;
	int   results_checked;
	int   typed_rows;
	bit   sender_idle_on;
	bit   sink_idle_on;
	bit   hold_request;

	// Directed rows: typed expectations where the answer is plain, predictor otherwise.
	pixel_case_t directed_cases [NUM_DIRECTED] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     8'd0,   8'd0}},
		'{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     8'd0,   8'd255}},
		'{8'd128, 8'd128, 8'd128, 1'b1, '{15'd0,     8'd0,   8'd128}},
		'{8'd1,   8'd1,   8'd1,   1'b1, '{15'd0,     8'd0,   8'd1}},
		'{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     8'd255, 8'd255}},
		'{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  8'd255, 8'd255}},
		'{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 8'd255, 8'd255}},
		'{8'd255, 8'd255, 8'd0,   1'b1, '{15'd3840,  8'd255, 8'd255}},
		'{8'd0,   8'd255, 8'd255, 1'b1, '{15'd11520, 8'd255, 8'd255}},
		'{8'd255, 8'd0,   8'd255, 1'b1, '{15'd19200, 8'd255, 8'd255}},
		'{8'd1,   8'd0,   8'd0,   1'b0, '0},
		'{8'd0,   8'd1,   8'd0,   1'b0, '0},
		'{8'd0,   8'd0,   8'd1,   1'b0, '0},
		'{8'd255, 8'd0,   8'd1,   1'b0, '0},
		'{8'd255, 8'd254, 8'd255, 1'b0, '0},
		'{8'd10,  8'd200, 8'd30,  1'b0, '0},
		'{8'd40,  8'd60,  8'd250, 1'b0, '0},
		'{8'd255, 8'd128, 8'd64,  1'b0, '0},
		'{8'd64,  8'd255, 8'd254, 1'b0, '0},
		'{8'd254, 8'd255, 8'd255, 1'b0, '0},
		'{8'd170, 8'd85,  8'd85,  1'b0, '0},
		'{8'd1,   8'd255, 8'd0,   1'b0, '0}
	};

	rgb_to_hsv_converter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.hsv_valid   (hsv_valid),
		.hsv_stall   (hsv_stall),
		.hue         (hue),
		.saturation  (saturation),
		.brightness  (brightness)
	);

	function automatic hsv_t predict_hsv(input logic [CH_W-1:0] r, g, b);
		int      ri, gi, bi, hi, lo, span, num, base, h;
		sector_t sect;
		hsv_t    res;
		ri = r;
		gi = g;
		bi = b;
		hi = ri;
		lo = ri;
		if (gi > hi) hi = gi;
		if (bi > hi) hi = bi;
		if (gi < lo) lo = gi;
		if (bi < lo) lo = bi;
		span = hi - lo;
		h = 0;
		if (span != 0) begin
			// ties go to red, then green
			if (hi == ri)      sect = SECT_RED;
			else if (hi == gi) sect = SECT_GREEN;
			else               sect = SECT_BLUE;
			case (sect)
				SECT_RED: begin
					num = gi - bi;
					base = 0;
				end
				SECT_GREEN: begin
					num = bi - ri;
					base = int'(HUE_GREEN);
				end
				default: begin
					num = ri - gi;
					base = int'(HUE_BLUE);
				end
			endcase
			// integer division truncates toward zero; wrap negatives up into one turn
			h = (base + (num * HUE_PER_SIXTY) / span) % int'(HUE_TURN);
			if (h < 0) h += int'(HUE_TURN);
		end
		res.hue = HUE_W'(h);
		res.sat = (hi != 0) ? CH_W'((CH_MAX * span) / hi) : '0;
		res.val = CH_W'(hi);
		return res;
	endfunction

	// Random pixel shaped toward greys, ties and extremes as well as plain noise.
	task automatic pick_pixel(output logic [CH_W-1:0] r, g, b);
		int kind;
		int top;
		kind = $urandom_range(0, 9);
		r = CH_W'($urandom_range(0, CH_MAX));
		g = CH_W'($urandom_range(0, CH_MAX));
		b = CH_W'($urandom_range(0, CH_MAX));
		case (kind)
			5: begin
				g = r;
				b = r;
			end
			6: begin
				top = $urandom_range(1, CH_MAX);
				case ($urandom_range(0, 2))
					0: begin
						r = CH_W'(top);
						g = CH_W'(top);
						b = CH_W'($urandom_range(0, top));
					end
					1: begin
						g = CH_W'(top);
						b = CH_W'(top);
						r = CH_W'($urandom_range(0, top));
					end
					default: begin
						r = CH_W'(top);
						b = CH_W'(top);
						g = CH_W'($urandom_range(0, top));
					end
				endcase
			end
			7: begin
				if ($urandom_range(0, 2) != 0) r = CH_W'($urandom_range(0, 1) ? CH_MAX : 0);
				if ($urandom_range(0, 2) != 0) g = CH_W'($urandom_range(0, 1) ? CH_MAX : 0);
				if ($urandom_range(0, 2) != 0) b = CH_W'($urandom_range(0, 1) ? CH_MAX : 0);
			end
			8: begin
				case ($urandom_range(0, 2))
					0: r = CH_W'($urandom_range(CH_MAX - 3, CH_MAX));
					1: g = CH_W'($urandom_range(CH_MAX - 3, CH_MAX));
					default: b = CH_W'($urandom_range(CH_MAX - 3, CH_MAX));
				endcase
			end
			9: begin
				r = CH_W'($urandom_range(0, 3));
				g = CH_W'($urandom_range(0, 3));
				b = CH_W'($urandom_range(0, 3));
			end
			default: ;
		endcase
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic offer_pixel(input logic [CH_W-1:0] r, g, b, input hsv_t want);
		if (sender_idle_on && $urandom_range(0, 3) == 0) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do begin
			@(posedge clk);
		end while (pixel_stall !== 1'b0);
		hsv_expected_q.push_back(want);
		pixels_sent++;
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout, %0d results still outstanding", $time, hsv_expected_q.size());
		$display("testbench NOT OK");
		$finish;
	end

	// Output side: random stall bursts, plus one long hold-off to back the pipeline up.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hsv_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hsv_stall <= 1'b0;
				hold_request = 1'b0;
			end else if (sink_idle_on && arst_n && $urandom_range(0, 4) == 0) begin
				hsv_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				hsv_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && hsv_valid === 1'b1 && hsv_stall === 1'b0) begin
			if (hsv_expected_q.size() == 0) begin
				$display("%0t: unexpected result hue=%0d sat=%0d val=%0d",
					$time, hue, saturation, brightness);
				fail_count++;
			end else begin
				oldest_hsv = hsv_expected_q.pop_front();
				results_checked++;
				if (hue !== oldest_hsv.hue) begin
					$display("%0t: hue mismatch, expected %0d actual %0d",
						$time, oldest_hsv.hue, hue);
					fail_count++;
				end
				if (saturation !== oldest_hsv.sat) begin
					$display("%0t: saturation mismatch, expected %0d actual %0d",
						$time, oldest_hsv.sat, saturation);
					fail_count++;
				end
				if (brightness !== oldest_hsv.val) begin
					$display("%0t: brightness mismatch, expected %0d actual %0d",
						$time, oldest_hsv.val, brightness);
					fail_count++;
				end
			end
		end
	end

	initial begin
		logic [CH_W-1:0] r, g, b;
		pixel_case_t     row;
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		hsv_stall = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		fail_count = 0;
		pixels_sent = 0;
		results_checked = 0;
		typed_rows = 0;
		sender_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		hold_request = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed_cases[i]) begin
			row = directed_cases[i];
			if (row.typed) typed_rows++;
			offer_pixel(row.r, row.g, row.b,
				row.typed ? row.want : predict_hsv(row.r, row.g, row.b));
		end

		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n == HOLD_AT_ITEM) hold_request = 1'b1;
			if (n == NUM_RANDOM - QUIET_TAIL) begin
				sender_idle_on = 1'b0;
				sink_idle_on = 1'b0;
			end
			pick_pixel(r, g, b);
			offer_pixel(r, g, b, predict_hsv(r, g, b));
		end
		pixel_valid <= 1'b0;

		wait (hsv_expected_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d pixels (%0d directed, %0d with fixed answers), checked %0d results.",
			pixels_sent, NUM_DIRECTED, typed_rows, results_checked);
		$display("Covered greys, ties, sector wrap, extremes and one long output hold-off.");
		if (fail_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
